@@ rtl/mlpd_pkg.sv @@
// Shared types and constants of the multi-level long-press detector.
`default_nettype none

package mlpd_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int MAX_LEVELS  = 4;
    localparam int NUM_THRESH  = 4;
    localparam int DUR_W       = 24;
    localparam int LVL_W       = 3;
    localparam int THR_W       = 24;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    // Highest level that can ever be in use.
    localparam int LEVEL_LIMIT = (MAX_LEVELS < NUM_THRESH) ? MAX_LEVELS : NUM_THRESH;

    // Register indexes
    localparam logic [2:0] REG_PRESSED_HIGH    = 3'd0;
    localparam logic [2:0] REG_LEVEL_COUNT     = 3'd1;
    localparam logic [2:0] REG_THRESHOLD_ONE   = 3'd2;
    localparam logic [2:0] REG_THRESHOLD_TWO   = 3'd3;
    localparam logic [2:0] REG_THRESHOLD_THREE = 3'd4;
    localparam logic [2:0] REG_THRESHOLD_FOUR  = 3'd5;

    localparam logic             PRESSED_HIGH_RESET = 1'b0;
    localparam logic [LVL_W-1:0] LEVEL_COUNT_RESET  = 3'd4;
    localparam logic [THR_W-1:0] THRESHOLD_ONE_RESET   = 24'd50;
    localparam logic [THR_W-1:0] THRESHOLD_TWO_RESET   = 24'd1000;
    localparam logic [THR_W-1:0] THRESHOLD_THREE_RESET = 24'd3000;
    localparam logic [THR_W-1:0] THRESHOLD_FOUR_RESET  = 24'd6000;

    typedef struct packed {
        logic                              pressed_high;
        logic [LVL_W-1:0]                  level_count;
        logic [NUM_THRESH-1:0][THR_W-1:0]  threshold;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/mlpd_regs.sv @@
// APB configuration registers of the long-press detector.
`default_nettype none

module mlpd_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mlpd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mlpd_pkg::DATA_W-1:0]   pwdata,
    output logic      [mlpd_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output mlpd_pkg::cfg_t                     cfg
);

    mlpd_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pressed_high <= mlpd_pkg::PRESSED_HIGH_RESET;
            cfg_reg.level_count  <= mlpd_pkg::LEVEL_COUNT_RESET;
            cfg_reg.threshold[0] <= mlpd_pkg::THRESHOLD_ONE_RESET;
            cfg_reg.threshold[1] <= mlpd_pkg::THRESHOLD_TWO_RESET;
            cfg_reg.threshold[2] <= mlpd_pkg::THRESHOLD_THREE_RESET;
            cfg_reg.threshold[3] <= mlpd_pkg::THRESHOLD_FOUR_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                mlpd_pkg::REG_PRESSED_HIGH:    cfg_reg.pressed_high <= pwdata[0];
                mlpd_pkg::REG_LEVEL_COUNT:
                    cfg_reg.level_count <= pwdata[mlpd_pkg::LVL_W-1:0];
                mlpd_pkg::REG_THRESHOLD_ONE:
                    cfg_reg.threshold[0] <= pwdata[mlpd_pkg::THR_W-1:0];
                mlpd_pkg::REG_THRESHOLD_TWO:
                    cfg_reg.threshold[1] <= pwdata[mlpd_pkg::THR_W-1:0];
                mlpd_pkg::REG_THRESHOLD_THREE:
                    cfg_reg.threshold[2] <= pwdata[mlpd_pkg::THR_W-1:0];
                mlpd_pkg::REG_THRESHOLD_FOUR:
                    cfg_reg.threshold[3] <= pwdata[mlpd_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            mlpd_pkg::REG_PRESSED_HIGH:    prdata[0] = cfg_reg.pressed_high;
            mlpd_pkg::REG_LEVEL_COUNT:
                prdata[mlpd_pkg::LVL_W-1:0] = cfg_reg.level_count;
            mlpd_pkg::REG_THRESHOLD_ONE:
                prdata[mlpd_pkg::THR_W-1:0] = cfg_reg.threshold[0];
            mlpd_pkg::REG_THRESHOLD_TWO:
                prdata[mlpd_pkg::THR_W-1:0] = cfg_reg.threshold[1];
            mlpd_pkg::REG_THRESHOLD_THREE:
                prdata[mlpd_pkg::THR_W-1:0] = cfg_reg.threshold[2];
            mlpd_pkg::REG_THRESHOLD_FOUR:
                prdata[mlpd_pkg::THR_W-1:0] = cfg_reg.threshold[3];
            default: prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/mlpd_core.sv @@
// Press timing state, level tracking and result register of the detector.
`default_nettype none

module mlpd_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire mlpd_pkg::cfg_t                   cfg,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             pin_level,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  release_seen,
    output logic      [mlpd_pkg::DUR_W-1:0]       press_duration,
    output logic      [mlpd_pkg::LVL_W-1:0]       release_level,
    output logic      [mlpd_pkg::LVL_W-1:0]       present_level,
    output logic                                  pressed_now,
    output logic                                  top_level_reached
);

    localparam int WIDE = mlpd_pkg::COUNT_WIDTH + mlpd_pkg::DUR_W + 1;
    localparam logic [mlpd_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [WIDE-1:0] COUNT_MAX_W = WIDE'(COUNT_MAX);
    localparam logic [WIDE-1:0] DUR_MAX_W   = WIDE'({mlpd_pkg::DUR_W{1'b1}});
    localparam logic [mlpd_pkg::LVL_W-1:0] LEVEL_LIMIT_L =
        mlpd_pkg::LVL_W'(mlpd_pkg::LEVEL_LIMIT);

    logic                                last_pin_reg,  last_pin_next;
    logic                                timing_reg,    timing_next;
    logic [mlpd_pkg::COUNT_WIDTH-1:0]    elapsed_reg,   elapsed_next;
    logic [mlpd_pkg::LVL_W-1:0]          level_reg,     level_next;
    logic                                top_note_reg,  top_note_next;
    logic                                out_valid_reg;

    logic                                rel_reg,   rel_next;
    logic [mlpd_pkg::DUR_W-1:0]          dur_reg,   dur_next;
    logic [mlpd_pkg::LVL_W-1:0]          rlev_reg,  rlev_next;
    logic [mlpd_pkg::LVL_W-1:0]          plev_reg;
    logic                                press_reg, press_next;
    logic                                top_reg,   top_next;

    logic                                accept;
    logic                                pressed;
    logic                                pin_edge;
    logic [mlpd_pkg::LVL_W-1:0]          n_active;
    logic [mlpd_pkg::LVL_W-1:0]          cand;
    logic [WIDE-1:0]                     dur_wide;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign pressed  = (pin_level == cfg.pressed_high);
    assign pin_edge = (pin_level != last_pin_reg);
    assign n_active = (cfg.level_count > LEVEL_LIMIT_L) ? LEVEL_LIMIT_L : cfg.level_count;

    always_comb
    begin
        last_pin_next = last_pin_reg;
        timing_next   = timing_reg;
        elapsed_next  = elapsed_reg;
        level_next    = level_reg;
        top_note_next = top_note_reg;
        rel_next      = 1'b0;
        dur_next      = '0;
        rlev_next     = '0;
        press_next    = pressed;
        top_next      = 1'b0;
        cand          = '0;

        // elapsed + 1 capped by the counter and by the output field
        dur_wide = WIDE'(elapsed_reg) + WIDE'(1);
        if (dur_wide > COUNT_MAX_W)
            dur_wide = COUNT_MAX_W;
        if (dur_wide > DUR_MAX_W)
            dur_wide = DUR_MAX_W;

        if (pin_edge)
        begin
            last_pin_next = pin_level;
            if (pressed)
            begin
                timing_next   = 1'b1;
                elapsed_next  = '0;
                level_next    = '0;
                top_note_next = 1'b0;
            end
            else if (timing_reg)
            begin
                rel_next      = 1'b1;
                dur_next      = mlpd_pkg::DUR_W'(dur_wide);
                rlev_next     = level_reg;
                timing_next   = 1'b0;
                elapsed_next  = '0;
                level_next    = '0;
                top_note_next = 1'b0;
            end
        end
        else if (pressed && timing_reg && (elapsed_reg != COUNT_MAX))
        begin
            elapsed_next = elapsed_reg + 1'b1;
        end

        // ascending scan: the largest matching index wins
        for (int i = 0; i < mlpd_pkg::NUM_THRESH; i++)
        begin
            if ((mlpd_pkg::LVL_W'(i + 1) <= n_active) &&
                (elapsed_next >= mlpd_pkg::COUNT_WIDTH'(cfg.threshold[i])))
                cand = mlpd_pkg::LVL_W'(i + 1);
        end

        if (!rel_next && pressed && timing_next)
        begin
            if (cand > level_next)
                level_next = cand;
            if ((level_next == n_active) && !top_note_next)
            begin
                top_note_next = 1'b1;
                top_next      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pin_reg  <= !mlpd_pkg::PRESSED_HIGH_RESET;
            timing_reg    <= 1'b0;
            elapsed_reg   <= '0;
            level_reg     <= '0;
            top_note_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                last_pin_reg <= last_pin_next;
                timing_reg   <= timing_next;
                elapsed_reg  <= elapsed_next;
                level_reg    <= level_next;
                top_note_reg <= top_note_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rel_reg   <= rel_next;
            dur_reg   <= dur_next;
            rlev_reg  <= rlev_next;
            plev_reg  <= level_next;
            press_reg <= press_next;
            top_reg   <= top_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign release_seen      = rel_reg;
    assign press_duration    = dur_reg;
    assign release_level     = rlev_reg;
    assign present_level     = plev_reg;
    assign pressed_now       = press_reg;
    assign top_level_reached = top_reg;

endmodule

`default_nettype wire

@@ rtl/multi_level_long_press_detector.sv @@
// An accepted tick's result is in the output register from the cycle after it is accepted.
// Throughput: one tick per cycle; the output register takes a new result in the
// same cycle the previous one is taken, so only a stalled output holds the input.
// Reset (rst_n, async, active low): registers return to their documented values,
// the pin history to the released level, and no result is pending.
// Top level of the multi-level long-press detector.
`default_nettype none

module multi_level_long_press_detector (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mlpd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mlpd_pkg::DATA_W-1:0]   pwdata,
    output logic      [mlpd_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          pin_level,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               release_seen,
    output logic      [mlpd_pkg::DUR_W-1:0]    press_duration,
    output logic      [mlpd_pkg::LVL_W-1:0]    release_level,
    output logic      [mlpd_pkg::LVL_W-1:0]    present_level,
    output logic                               pressed_now,
    output logic                               top_level_reached
);

    mlpd_pkg::cfg_t cfg;

    mlpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mlpd_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .pin_level         (pin_level),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .release_seen      (release_seen),
        .press_duration    (press_duration),
        .release_level     (release_level),
        .present_level     (present_level),
        .pressed_now       (pressed_now),
        .top_level_reached (top_level_reached)
    );

`ifndef ASSERT_OFF
    // a reported release always leaves the level cleared
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && release_seen) |-> (present_level == '0 && !top_level_reached))
        else $error("release result with level not cleared");

    // duration and release level fields are zero unless a release is reported
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !release_seen) |-> (press_duration == '0 && release_level == '0))
        else $error("release fields set without release");

    // top pulse only while pressed
    a_top_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && top_level_reached) |-> pressed_now)
        else $error("top level pulse while not pressed");

    // a result is held until taken, so input stalls only behind it
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a pending result");
`endif

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for the multi-level long-press detector: predicts and checks every tick result.
`timescale 1ns / 1ps

module testbench;

    localparam logic [2:0] REG_UNMAPPED_SIX   = 3'd6;
    localparam logic [2:0] REG_UNMAPPED_SEVEN = 3'd7;
    localparam int         CYCLE_LIMIT        = 400000;
    localparam int         HOLD_OFF_CYCLES    = 150;

    typedef struct {
        logic                       released;
        logic [mlpd_pkg::DUR_W-1:0] duration;
        logic [mlpd_pkg::LVL_W-1:0] final_level;
        logic [mlpd_pkg::LVL_W-1:0] level;
        logic                       pressed;
        logic                       top;
    } tick_report_t;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [mlpd_pkg::ADDR_W-1:0] paddr     = '0;
    logic [mlpd_pkg::DATA_W-1:0] pwdata    = '0;
    logic [mlpd_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic                        pin_level = 1'b1;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic                        release_seen;
    logic [mlpd_pkg::DUR_W-1:0]  press_duration;
    logic [mlpd_pkg::LVL_W-1:0]  release_level;
    logic [mlpd_pkg::LVL_W-1:0]  present_level;
    logic                        pressed_now;
    logic                        top_level_reached;

    // Predictor copy of the registers and of the press tracking state
    logic                       cfg_pressed_high = mlpd_pkg::PRESSED_HIGH_RESET;
    logic [mlpd_pkg::LVL_W-1:0] cfg_levels       = mlpd_pkg::LEVEL_COUNT_RESET;
    logic [mlpd_pkg::THR_W-1:0] cfg_threshold [mlpd_pkg::NUM_THRESH];
    logic                       st_last_pin      = ~mlpd_pkg::PRESSED_HIGH_RESET;
    logic                       st_timing        = 1'b0;
    logic [mlpd_pkg::DUR_W-1:0] st_elapsed       = '0;
    logic [mlpd_pkg::LVL_W-1:0] st_level         = '0;
    logic                       st_top_sent      = 1'b0;

    tick_report_t reports_due [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    bit           gaps_on        = 1'b1;
    bit           stalls_on      = 1'b1;
    bit           hold_off_req   = 1'b0;

    multi_level_long_press_detector dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .pin_level         (pin_level),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .release_seen      (release_seen),
        .press_duration    (press_duration),
        .release_level     (release_level),
        .present_level     (present_level),
        .pressed_now       (pressed_now),
        .top_level_reached (top_level_reached)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cfg_threshold[0] = mlpd_pkg::THRESHOLD_ONE_RESET;
        cfg_threshold[1] = mlpd_pkg::THRESHOLD_TWO_RESET;
        cfg_threshold[2] = mlpd_pkg::THRESHOLD_THREE_RESET;
        cfg_threshold[3] = mlpd_pkg::THRESHOLD_FOUR_RESET;
    end

    // Advance the predicted detector by one tick and return its report
    function automatic tick_report_t predict_tick(input logic pin);
        tick_report_t               r;
        logic                       pressed;
        logic                       released;
        logic [mlpd_pkg::LVL_W-1:0] n;
        logic [mlpd_pkg::LVL_W-1:0] cand;
        logic                       found;
        r        = '{default: '0};
        pressed  = (pin == cfg_pressed_high);
        released = 1'b0;
        if (pin != st_last_pin) begin
            st_last_pin = pin;
            if (pressed) begin
                st_timing   = 1'b1;
                st_elapsed  = '0;
                st_level    = '0;
                st_top_sent = 1'b0;
            end
            else if (st_timing) begin
                r.released    = 1'b1;
                r.duration    = (st_elapsed == '1) ? st_elapsed : st_elapsed + 1'b1;
                r.final_level = st_level;
                st_timing     = 1'b0;
                st_elapsed    = '0;
                st_level      = '0;
                st_top_sent   = 1'b0;
                released      = 1'b1;
            end
        end
        else if (pressed && st_timing && st_elapsed != '1) begin
            st_elapsed = st_elapsed + 1'b1;
        end
        if (!released && pressed && st_timing) begin
            n     = (cfg_levels > mlpd_pkg::LEVEL_LIMIT)
                    ? mlpd_pkg::LVL_W'(mlpd_pkg::LEVEL_LIMIT) : cfg_levels;
            cand  = '0;
            found = 1'b0;
            // highest index that matches wins, even if thresholds are out of order
            for (int i = mlpd_pkg::NUM_THRESH; i >= 1; i--) begin
                if (!found && i <= n && st_elapsed >= cfg_threshold[i-1]) begin
                    cand  = mlpd_pkg::LVL_W'(i);
                    found = 1'b1;
                end
            end
            if (cand > st_level)
                st_level = cand;
            if (st_level == n && !st_top_sent) begin
                st_top_sent = 1'b1;
                r.top       = 1'b1;
            end
        end
        r.level   = st_level;
        r.pressed = pressed;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [mlpd_pkg::DUR_W-1:0] want,
                               input logic [mlpd_pkg::DUR_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Result check first, then prediction of the tick accepted at this edge
    always @(posedge clk)
    begin
        tick_report_t want;
        if (out_valid && out_ready) begin
            if (reports_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual release=%0b level=%0d",
                         $time, release_seen, present_level);
                mismatch_count++;
            end
            else begin
                want = reports_due.pop_front();
                check_field("release_seen", want.released, release_seen);
                check_field("press_duration", want.duration, press_duration);
                check_field("release_level", want.final_level, release_level);
                check_field("present_level", want.level, present_level);
                check_field("pressed_now", want.pressed, pressed_now);
                check_field("top_level_reached", want.top, top_level_reached);
            end
        end
        if (in_valid && in_ready)
            reports_due.push_back(predict_tick(pin_level));
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, reports_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (stalls_on && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_tick(input logic level);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        pin_level <= level;
        do @(posedge clk); while (!in_ready);
    endtask

    // Ticks given as a string of pin levels, first character first
    task automatic play(input string levels);
        for (int i = 0; i < levels.len(); i++)
            send_tick(levels[i] == "1");
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx,
                             input logic [mlpd_pkg::DATA_W-1:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mlpd_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mlpd_pkg::REG_PRESSED_HIGH:    cfg_pressed_high = value[0];
            mlpd_pkg::REG_LEVEL_COUNT:     cfg_levels       = value[mlpd_pkg::LVL_W-1:0];
            mlpd_pkg::REG_THRESHOLD_ONE:   cfg_threshold[0] = value[mlpd_pkg::THR_W-1:0];
            mlpd_pkg::REG_THRESHOLD_TWO:   cfg_threshold[1] = value[mlpd_pkg::THR_W-1:0];
            mlpd_pkg::REG_THRESHOLD_THREE: cfg_threshold[2] = value[mlpd_pkg::THR_W-1:0];
            mlpd_pkg::REG_THRESHOLD_FOUR:  cfg_threshold[3] = value[mlpd_pkg::THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_thresholds(input logic [mlpd_pkg::THR_W-1:0] t1,
                                  input logic [mlpd_pkg::THR_W-1:0] t2,
                                  input logic [mlpd_pkg::THR_W-1:0] t3,
                                  input logic [mlpd_pkg::THR_W-1:0] t4);
        write_reg(mlpd_pkg::REG_THRESHOLD_ONE, mlpd_pkg::DATA_W'(t1));
        write_reg(mlpd_pkg::REG_THRESHOLD_TWO, mlpd_pkg::DATA_W'(t2));
        write_reg(mlpd_pkg::REG_THRESHOLD_THREE, mlpd_pkg::DATA_W'(t3));
        write_reg(mlpd_pkg::REG_THRESHOLD_FOUR, mlpd_pkg::DATA_W'(t4));
    endtask

    // Writes past the last register must leave the reset settings alone
    task automatic test_reset_defaults();
        write_reg(REG_UNMAPPED_SIX, '1);
        write_reg(REG_UNMAPPED_SEVEN, '1);
        play("1001");
    endtask

    task automatic test_level_climb();
        write_reg(mlpd_pkg::REG_LEVEL_COUNT, 32'd4);
        set_thresholds(24'd0, 24'd1, 24'd2, 24'd3);
        play("000001");
    endtask

    // No levels in use: top pulse on the first timed tick
    task automatic test_zero_levels();
        write_reg(mlpd_pkg::REG_LEVEL_COUNT, 32'd0);
        play("001");
    endtask

    task automatic test_wide_count_unordered();
        write_reg(mlpd_pkg::REG_LEVEL_COUNT, 32'd7);
        set_thresholds(24'd5, 24'd0, 24'hFFFFFF, 24'd2);
        play("0001");
    endtask

    // Polarity flipped mid-press, then a release edge with no press being timed
    task automatic test_polarity_switch();
        play("00");
        write_reg(mlpd_pkg::REG_PRESSED_HIGH, 32'd1);
        play("010");
        write_reg(mlpd_pkg::REG_PRESSED_HIGH, 32'd0);
        play("01");
    endtask

    task automatic test_random_presses(input int phase, input int n_ticks);
        logic [mlpd_pkg::THR_W-1:0] thr [mlpd_pkg::NUM_THRESH];
        logic [2:0]                 levels;
        int                         sent;
        int                         len;
        logic                       down;
        thr[0] = '0;
        case (phase % 4)
            0: begin
                thr[0] = mlpd_pkg::THR_W'($urandom_range(0, 12));
                for (int k = 1; k < mlpd_pkg::NUM_THRESH; k++)
                    thr[k] = thr[k-1] + mlpd_pkg::THR_W'($urandom_range(0, 12));
            end
            1: for (int k = 0; k < mlpd_pkg::NUM_THRESH; k++)
                   thr[k] = mlpd_pkg::THR_W'($urandom_range(0, 40));
            2: for (int k = 0; k < mlpd_pkg::NUM_THRESH; k++)
                   case ($urandom_range(0, 2))
                       0: thr[k] = '0;
                       1: thr[k] = '1;
                       default: thr[k] = mlpd_pkg::THR_W'($urandom_range(0, 30));
                   endcase
            default: begin
                for (int k = 0; k < mlpd_pkg::NUM_THRESH; k++)
                    thr[k] = mlpd_pkg::THR_W'($urandom());
                thr[$urandom_range(0, mlpd_pkg::NUM_THRESH-1)] =
                    mlpd_pkg::THR_W'($urandom_range(0, 20));
            end
        endcase
        case (phase)
            0: levels = 3'd0;
            1: levels = 3'd7;
            2: levels = 3'd4;
            3: levels = 3'd1;
            default: levels = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                          : 3'($urandom_range(1, 4));
        endcase
        write_reg(mlpd_pkg::REG_PRESSED_HIGH, mlpd_pkg::DATA_W'($urandom_range(0, 1)));
        write_reg(mlpd_pkg::REG_LEVEL_COUNT, mlpd_pkg::DATA_W'(levels));
        set_thresholds(thr[0], thr[1], thr[2], thr[3]);
        if (phase == 2)
            hold_off_req = 1'b1;
        down = cfg_pressed_high;
        sent = 0;
        while (sent < n_ticks) begin
            if ($urandom_range(0, 9) == 0) begin
                send_tick(logic'($urandom_range(0, 1)));
                sent++;
            end
            else begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
                repeat (len) send_tick(down);
                sent += len;
                len = $urandom_range(1, 8);
                repeat (len) send_tick(~down);
                sent += len;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_level_climb();
        test_zero_levels();
        test_wide_count_unordered();
        test_polarity_switch();
        for (int phase = 0; phase < 16; phase++) begin
            // last stretch runs with no idling on either side
            if (phase == 12) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            test_random_presses(phase, 60);
        end
        settle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
rtl/mlpd_pkg.sv
rtl/mlpd_regs.sv
rtl/mlpd_core.sv
rtl/multi_level_long_press_detector.sv
verif/testbench.sv
